// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, muted while reset is asserted.
`define SFTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define SFTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/sfta_pkg.sv =====
// ----------------------------------------------------------------------------
// sfta_pkg
// Types and constants of the strip/fan triangle assembler.
// ----------------------------------------------------------------------------
package sfta_pkg;

    localparam int WORD_W      = 16;
    localparam int REC_W       = 4 * WORD_W;
    localparam int CORNER_W    = 2;
    localparam int OUT_USER_W  = 4;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [REC_W-1:0]         t_vertex_rec;

    // Word position inside a four-word vertex record
    localparam logic [1:0] SLOT_VERT = 2'd0;
    localparam logic [1:0] SLOT_NORM = 2'd1;
    localparam logic [1:0] SLOT_S    = 2'd2;
    localparam logic [1:0] SLOT_T    = 2'd3;

    // Vertex number inside a primitive, saturating
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_LATER  = 2'd3;

    // Triangle corner codes
    localparam logic [CORNER_W-1:0] CORNER_A = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_B = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_C = 2'd2;

endpackage

// ===== rtl/core/strip_fan_triangle_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// strip_fan_triangle_assembler_unit
// Assembles triangles from a packed strip/fan command stream of 16-bit words.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   16     tdata: word (header or vertex record word)
// m_axis    out  64+4   tdata: vert_index, norm_index, tex_s, tex_t
//                       tuser: corner, is_fan, mesh_done; tlast: triangle_last
//
// One word is taken per cycle. A word that closes a triangle loads a three-beat
// corner burst, read straight out of the corner slots, one corner a cycle while the sink takes them.
// Since a record is four words long the burst drains before the next one can
// be due, so the stream runs at one word a cycle unless the sink stalls.
// A word that would touch the corner slots waits while a burst or a mesh-done
// request is still held. A mesh end waits only on a held mesh-done request
// that the sink is not taking in the same cycle. Other words pass freely.
// Synchronous active-low reset; the record and corner stores are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strip_fan_triangle_assembler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sfta_pkg::WORD_W-1:0]         s_axis_tdata,   // [15:0] word
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] vert_index, [31:16] norm_index, [47:32] tex_s, [63:48] tex_t
    output logic [sfta_pkg::REC_W-1:0]          m_axis_tdata,
    output logic                                m_axis_tlast,   // triangle_last
    // [1:0] corner, [2] is_fan, [3] mesh_done
    output logic [sfta_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import sfta_pkg::*;

    // Stream parser state
    logic                r_expect_header, n_expect_header;
    logic                r_fan_mode,      n_fan_mode;
    logic [WORD_W-1:0]   r_vert_left,     n_vert_left;
    logic [1:0]          r_vert_pos,      n_vert_pos;
    logic                r_strip_parity,  n_strip_parity;
    logic [1:0]          r_word_slot,     n_word_slot;

    // Output side
    logic                r_tri_busy,      n_tri_busy;
    logic [CORNER_W-1:0] r_tri_idx,       n_tri_idx;
    logic                r_out_fan,       n_out_fan;
    logic                r_mesh_pend,     n_mesh_pend;

    // Payload stores
    t_word               r_rec_word [3];
    t_vertex_rec         r_corner   [3];

    logic                in_fire;
    logic                out_fire;
    logic                mesh_drain;
    logic                is_zero_hdr;
    logic                is_last_word;
    logic                in_hold;
    logic                closes_tri;
    logic [WORD_W-1:0]   left_dec;
    t_vertex_rec         new_rec;
    t_vertex_rec         sel_corner;

    assign is_zero_hdr  = (s_axis_tdata == '0);
    assign is_last_word = !r_expect_header && (r_word_slot == SLOT_T);
    assign closes_tri   = is_last_word && (r_vert_pos != POS_FIRST)
                          && (r_vert_pos != POS_SECOND);

    // Mesh-done request leaving this cycle frees the slot for the next one
    assign mesh_drain = out_fire && !r_tri_busy;

    // Hold only the words that need the output side free
    assign in_hold = r_expect_header ? (is_zero_hdr && r_mesh_pend && !mesh_drain)
                                     : (is_last_word && (r_tri_busy || r_mesh_pend));

    assign s_axis_tready = !in_hold;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    assign left_dec = r_vert_left - 1'b1;
    assign new_rec  = {s_axis_tdata, r_rec_word[2], r_rec_word[1], r_rec_word[0]};

    // Next-state logic
    always_comb begin
        n_expect_header = r_expect_header;
        n_fan_mode      = r_fan_mode;
        n_vert_left     = r_vert_left;
        n_vert_pos      = r_vert_pos;
        n_strip_parity  = r_strip_parity;
        n_word_slot     = r_word_slot;
        n_tri_busy      = r_tri_busy;
        n_tri_idx       = r_tri_idx;
        n_out_fan       = r_out_fan;
        n_mesh_pend     = r_mesh_pend;

        // Drain side: triangle corners first, then a pending mesh end
        if (out_fire) begin
            if (r_tri_busy) begin
                if (r_tri_idx == CORNER_C) begin
                    n_tri_busy = 1'b0;
                end else begin
                    n_tri_idx = r_tri_idx + 1'b1;
                end
            end else begin
                n_mesh_pend = 1'b0;
            end
        end

        if (in_fire) begin
            if (r_expect_header) begin
                if (is_zero_hdr) begin
                    n_mesh_pend = 1'b1;
                end else begin
                    n_fan_mode      = s_axis_tdata[WORD_W-1];
                    n_vert_left     = s_axis_tdata[WORD_W-1] ? (~s_axis_tdata + 1'b1)
                                                             : s_axis_tdata;
                    n_expect_header = 1'b0;
                    n_vert_pos      = POS_FIRST;
                    n_strip_parity  = 1'b0;
                    n_word_slot     = SLOT_VERT;
                end
            end else if (!is_last_word) begin
                n_word_slot = r_word_slot + 1'b1;
            end else begin
                n_word_slot    = SLOT_VERT;
                n_vert_left    = left_dec;
                n_strip_parity = ~r_strip_parity;
                if (r_vert_pos != POS_LATER) begin
                    n_vert_pos = r_vert_pos + 1'b1;
                end
                if (left_dec == '0) begin
                    n_expect_header = 1'b1;
                end
                if (closes_tri) begin
                    n_tri_busy = 1'b1;
                    n_tri_idx  = CORNER_A;
                    n_out_fan  = r_fan_mode;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_fan_mode      <= 1'b0;
            r_vert_left     <= '0;
            r_vert_pos      <= POS_FIRST;
            r_strip_parity  <= 1'b0;
            r_word_slot     <= SLOT_VERT;
            r_tri_busy      <= 1'b0;
            r_tri_idx       <= CORNER_A;
            r_out_fan       <= 1'b0;
            r_mesh_pend     <= 1'b0;
        end else begin
            r_expect_header <= n_expect_header;
            r_fan_mode      <= n_fan_mode;
            r_vert_left     <= n_vert_left;
            r_vert_pos      <= n_vert_pos;
            r_strip_parity  <= n_strip_parity;
            r_word_slot     <= n_word_slot;
            r_tri_busy      <= n_tri_busy;
            r_tri_idx       <= n_tri_idx;
            r_out_fan       <= n_out_fan;
            r_mesh_pend     <= n_mesh_pend;
        end
    end

    // First three words of the record in flight
    always_ff @(posedge i_clk) begin
        if (in_fire && !r_expect_header) begin
            unique case (r_word_slot)
                SLOT_VERT: r_rec_word[0] <= s_axis_tdata;
                SLOT_NORM: r_rec_word[1] <= s_axis_tdata;
                SLOT_S:    r_rec_word[2] <= s_axis_tdata;
                SLOT_T:    ;
            endcase
        end
    end

    // Corner slots: fans pin A, strips swap the oldest corner out by parity
    always_ff @(posedge i_clk) begin
        if (in_fire && is_last_word) begin
            unique case (r_vert_pos)
                POS_FIRST:  r_corner[0] <= new_rec;
                POS_SECOND: r_corner[2] <= new_rec;
                POS_THIRD:  r_corner[1] <= new_rec;
                POS_LATER: begin
                    if (r_fan_mode) begin
                        r_corner[2] <= r_corner[1];
                        r_corner[1] <= new_rec;
                    end else if (!r_strip_parity) begin
                        r_corner[0] <= r_corner[1];
                        r_corner[1] <= new_rec;
                    end else begin
                        r_corner[0] <= r_corner[2];
                        r_corner[2] <= new_rec;
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_tri_idx)
            CORNER_A: sel_corner = r_corner[0];
            CORNER_B: sel_corner = r_corner[1];
            default:  sel_corner = r_corner[2];
        endcase
    end

    // Result mux: a mesh-done request carries zero payload
    assign m_axis_tvalid = r_tri_busy || r_mesh_pend;
    assign m_axis_tdata  = r_tri_busy ? sel_corner : '0;
    assign m_axis_tlast  = r_tri_busy ? (r_tri_idx == CORNER_C) : 1'b1;
    assign m_axis_tuser  = r_tri_busy ? {1'b0, r_out_fan, r_tri_idx}
                                      : {1'b1, 1'b0, CORNER_A};

    `SFTA_ASSERT(a_tri_load_idle, i_clk, i_rst_n,
        (in_fire && closes_tri) |-> (!r_tri_busy && !r_mesh_pend),
        "triangle loaded while output side busy")
    `SFTA_ASSERT(a_burst_starts_at_a, i_clk, i_rst_n,
        $rose(r_tri_busy) |-> (r_tri_idx == CORNER_A),
        "corner burst does not start at corner A")
    `SFTA_ASSERT(a_burst_ends_on_c, i_clk, i_rst_n,
        (out_fire && r_tri_busy && (r_tri_idx == CORNER_C)) |=> !r_tri_busy,
        "corner burst continues past corner C")
    `SFTA_ASSERT_ALWAYS(a_hdr_slot_zero, i_clk,
        r_expect_header |-> (r_word_slot == SLOT_VERT),
        "record slot not cleared while awaiting header")

endmodule
